// ===== rtl/core/scci_pkg.sv =====
// Shared types, widths and helpers for the segment/circle intersection core.
// No dependencies; every other file in rtl/core imports this package.
package scci_pkg;

   localparam int CrdW    = 33;   // coordinate relative to the circle center
   localparam int DltW    = 34;   // segment delta
   localparam int MagW    = 33;   // magnitude of a delta
   localparam int LenW    = 67;   // squared segment length
   localparam int DiscW   = 128;  // discriminant
   localparam int RootW   = 64;   // floor square root of the discriminant
   localparam int RemW    = 66;   // square-root partial remainder
   localparam int ProdW   = 97;   // magnitude of one numerator term
   localparam int NumW    = 99;   // signed numerator
   localparam int NumMagW = 98;   // numerator magnitude
   localparam int QW      = 40;   // quotient bits kept before overflow
   localparam int DivRemW = 67;   // divider partial remainder
   localparam int Lanes   = 4;

   // divider lane assignment
   localparam int LaneX0 = 0;
   localparam int LaneY0 = 1;
   localparam int LaneX1 = 2;
   localparam int LaneY1 = 3;

   localparam logic signed [41:0] SatHi = 42'sd2147483647;
   localparam logic signed [41:0] SatLo = -42'sd2147483648;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic        [30:0] radius;
   } req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic               found;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic                   ok;
      logic signed [CrdW-1:0] minx;
      logic signed [CrdW-1:0] maxx;
      logic signed [31:0]     cx;
      logic signed [31:0]     cy;
      logic [LenW-1:0]        len2;
      logic [MagW-1:0]        dxm;
      logic [MagW-1:0]        dym;
      logic                   dneg;
      logic                   dxneg;
      logic                   dyneg;
      logic [ProdW-1:0]       am;
      logic [ProdW-1:0]       cm;
   } root_side_type;

   typedef struct packed {
      logic               v;
      logic [DiscW-1:0]   n;
      logic [RemW-1:0]    rem;
      logic [RootW-1:0]   root;
      root_side_type      side;
   } root_token_type;

   typedef struct packed {
      logic                   ok;
      logic signed [CrdW-1:0] minx;
      logic signed [CrdW-1:0] maxx;
      logic signed [31:0]     cx;
      logic signed [31:0]     cy;
      logic [LenW-1:0]        len2;
      logic [Lanes-1:0]       neg;
      logic [Lanes-1:0]       ovf;
   } div_side_type;

   typedef struct packed {
      logic [DivRemW-1:0] rem;
      logic [QW-1:0]      lo;
      logic [QW-1:0]      q;
   } div_lane_type;

   typedef struct packed {
      logic                          v;
      div_lane_type [Lanes-1:0]      lane;
      div_side_type                  side;
   } div_token_type;

   function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
      logic signed [31:0] r;
      if (v > SatHi) begin
         r = 32'sh7fffffff;
      end else if (v < SatLo) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/scci_root_cell.sv =====
// One step of the pipelined integer square root: two radicand bits, one root bit.
// Depends on scci_pkg for the token type.
module scci_root_cell import scci_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           adv,
   input  root_token_type up_tok,
   output root_token_type dn_tok
);

   root_token_type tok_ff, tok_in;
   logic [RemW+1:0] t, trial, diff;
   logic            ge;

   always_comb begin
      t        = {up_tok.rem, up_tok.n[DiscW-1 -: 2]};
      trial    = {2'b00, up_tok.root, 2'b01};
      diff     = t - trial;
      ge       = t >= trial;
      tok_in   = up_tok;
      tok_in.n = {up_tok.n[DiscW-3:0], 2'b00};
      tok_in.rem  = ge ? diff[RemW-1:0] : t[RemW-1:0];
      tok_in.root = {up_tok.root[RootW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.v <= 1'b0;
      end else if (adv) begin
         tok_ff <= tok_in;
      end
   end

   assign dn_tok = tok_ff;

endmodule

// ===== rtl/core/scci_div_cell.sv =====
// One restoring-division step on all four numerator lanes: one quotient bit each.
// Depends on scci_pkg for the token type.
module scci_div_cell import scci_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  div_token_type up_tok,
   output div_token_type dn_tok
);

   div_token_type    tok_ff, tok_in;
   logic [DivRemW:0] t    [Lanes];
   logic [DivRemW:0] diff [Lanes];
   logic             ge   [Lanes];

   always_comb begin
      tok_in = up_tok;
      for (int k = 0; k < Lanes; k++) begin
         t[k]    = {up_tok.lane[k].rem, up_tok.lane[k].lo[QW-1]};
         diff[k] = t[k] - {1'b0, up_tok.side.len2};
         ge[k]   = t[k] >= {1'b0, up_tok.side.len2};
         tok_in.lane[k].rem = ge[k] ? diff[k][DivRemW-1:0] : t[k][DivRemW-1:0];
         tok_in.lane[k].lo  = {up_tok.lane[k].lo[QW-2:0], 1'b0};
         tok_in.lane[k].q   = {up_tok.lane[k].q[QW-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.v <= 1'b0;
      end else if (adv) begin
         tok_ff <= tok_in;
      end
   end

   assign dn_tok = tok_ff;

endmodule

// ===== rtl/core/scci_front.sv =====
// Front pipeline: centering, deltas, determinant, squared length and discriminant.
// Depends on scci_pkg; feeds the first square-root cell.
module scci_front import scci_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           adv,
   input  logic           in_v,
   input  req_type        in_data,
   output root_token_type out_tok
);

   // stage 1
   logic                   f1_v_ff;
   logic signed [CrdW-1:0] f1_sx_ff, f1_sy_ff, f1_ex_ff, f1_ey_ff;
   logic signed [CrdW-1:0] f1_sx_in, f1_sy_in, f1_ex_in, f1_ey_in;
   logic signed [31:0]     f1_cx_ff, f1_cy_ff;
   logic [30:0]            f1_r_ff;

   // stage 2
   logic                   f2_v_ff;
   logic signed [DltW-1:0] f2_dx_ff, f2_dy_ff, f2_dx_in, f2_dy_in;
   logic signed [65:0]     f2_p1_ff, f2_p2_ff, f2_p1_in, f2_p2_in;
   logic [61:0]            f2_r2_ff, f2_r2_in;
   logic signed [CrdW-1:0] f2_minx_ff, f2_maxx_ff;
   logic signed [31:0]     f2_cx_ff, f2_cy_ff;

   // stage 3
   logic                   f3_v_ff;
   logic signed [65:0]     f3_det_ff, f3_det_in;
   logic signed [67:0]     dxsq, dysq;
   logic signed [DltW-1:0] ndx, ndy;
   logic [65:0]            f3_dx2_ff, f3_dy2_ff;
   logic [MagW-1:0]        f3_dxm_ff, f3_dym_ff, f3_dxm_in, f3_dym_in;
   logic                   f3_dxneg_ff, f3_dyneg_ff;
   logic [61:0]            f3_r2_ff;
   logic signed [CrdW-1:0] f3_minx_ff, f3_maxx_ff;
   logic signed [31:0]     f3_cx_ff, f3_cy_ff;

   // stage 4
   logic                   f4_v_ff;
   logic [LenW-1:0]        f4_len2_ff, f4_len2_in;
   logic signed [65:0]     ndet;
   logic [64:0]            f4_dmag_ff, f4_dmag_in;
   logic                   f4_dneg_ff;
   logic [MagW-1:0]        f4_dxm_ff, f4_dym_ff;
   logic                   f4_dxneg_ff, f4_dyneg_ff;
   logic [61:0]            f4_r2_ff;
   logic signed [CrdW-1:0] f4_minx_ff, f4_maxx_ff;
   logic signed [31:0]     f4_cx_ff, f4_cy_ff;

   // stage 5: partial products
   logic                   f5_v_ff;
   logic [64:0]            f5_rll_ff, f5_rhl_ff;
   logic [63:0]            f5_rlh_ff, f5_rhh_ff;
   logic [63:0]            f5_dll_ff, f5_dlh_ff, f5_dhh_ff;
   logic [64:0]            f5_aml_ff, f5_amh_ff, f5_cml_ff, f5_cmh_ff;
   logic                   f5_ok_ff;
   logic [LenW-1:0]        f5_len2_ff;
   logic                   f5_dneg_ff;
   logic [MagW-1:0]        f5_dxm_ff, f5_dym_ff;
   logic                   f5_dxneg_ff, f5_dyneg_ff;
   logic signed [CrdW-1:0] f5_minx_ff, f5_maxx_ff;
   logic signed [31:0]     f5_cx_ff, f5_cy_ff;

   // stage 6: sums
   logic                   f6_v_ff;
   logic [DiscW-1:0]       f6_rl_ff, f6_rl_in, f6_d2_ff, f6_d2_in;
   logic [ProdW-1:0]       f6_am_ff, f6_am_in, f6_cm_ff, f6_cm_in;
   logic                   f6_ok_ff;
   logic [LenW-1:0]        f6_len2_ff;
   logic                   f6_dneg_ff;
   logic [MagW-1:0]        f6_dxm_ff, f6_dym_ff;
   logic                   f6_dxneg_ff, f6_dyneg_ff;
   logic signed [CrdW-1:0] f6_minx_ff, f6_maxx_ff;
   logic signed [31:0]     f6_cx_ff, f6_cy_ff;

   // stage 7: discriminant
   root_token_type         f7_tok_ff, f7_tok_in;
   logic [DiscW:0]         disc;

   always_comb begin
      f1_sx_in = {in_data.start_x[31], in_data.start_x} - {in_data.center_x[31], in_data.center_x};
      f1_sy_in = {in_data.start_y[31], in_data.start_y} - {in_data.center_y[31], in_data.center_y};
      f1_ex_in = {in_data.end_x[31], in_data.end_x} - {in_data.center_x[31], in_data.center_x};
      f1_ey_in = {in_data.end_y[31], in_data.end_y} - {in_data.center_y[31], in_data.center_y};

      f2_dx_in = {f1_ex_ff[CrdW-1], f1_ex_ff} - {f1_sx_ff[CrdW-1], f1_sx_ff};
      f2_dy_in = {f1_ey_ff[CrdW-1], f1_ey_ff} - {f1_sy_ff[CrdW-1], f1_sy_ff};
      f2_p1_in = f1_sx_ff * f1_ey_ff;
      f2_p2_in = f1_ex_ff * f1_sy_ff;
      f2_r2_in = f1_r_ff * f1_r_ff;

      f3_det_in = f2_p1_ff - f2_p2_ff;
      dxsq      = f2_dx_ff * f2_dx_ff;
      dysq      = f2_dy_ff * f2_dy_ff;
      ndx       = -f2_dx_ff;
      ndy       = -f2_dy_ff;
      f3_dxm_in = f2_dx_ff[DltW-1] ? ndx[MagW-1:0] : f2_dx_ff[MagW-1:0];
      f3_dym_in = f2_dy_ff[DltW-1] ? ndy[MagW-1:0] : f2_dy_ff[MagW-1:0];

      f4_len2_in = {1'b0, f3_dx2_ff} + {1'b0, f3_dy2_ff};
      ndet       = -f3_det_ff;
      f4_dmag_in = f3_det_ff[65] ? ndet[64:0] : f3_det_ff[64:0];

      // products wrap at 128 bits, as the discriminant compare expects
      f6_rl_in = DiscW'(f5_rll_ff) + (DiscW'(f5_rlh_ff) << 34)
               + (DiscW'(f5_rhl_ff) << 31) + (DiscW'(f5_rhh_ff) << 65);
      f6_d2_in = DiscW'(f5_dll_ff) + (DiscW'(f5_dlh_ff) << 33) + (DiscW'(f5_dhh_ff) << 64);
      f6_am_in = ProdW'(f5_aml_ff) + (ProdW'(f5_amh_ff) << 32);
      f6_cm_in = ProdW'(f5_cml_ff) + (ProdW'(f5_cmh_ff) << 32);

      disc = {1'b0, f6_rl_ff} - {1'b0, f6_d2_ff};
      f7_tok_in.v    = f6_v_ff;
      f7_tok_in.n    = disc[DiscW-1:0];
      f7_tok_in.rem  = '0;
      f7_tok_in.root = '0;
      f7_tok_in.side.ok    = f6_ok_ff & ~disc[DiscW];
      f7_tok_in.side.minx  = f6_minx_ff;
      f7_tok_in.side.maxx  = f6_maxx_ff;
      f7_tok_in.side.cx    = f6_cx_ff;
      f7_tok_in.side.cy    = f6_cy_ff;
      f7_tok_in.side.len2  = f6_len2_ff;
      f7_tok_in.side.dxm   = f6_dxm_ff;
      f7_tok_in.side.dym   = f6_dym_ff;
      f7_tok_in.side.dneg  = f6_dneg_ff;
      f7_tok_in.side.dxneg = f6_dxneg_ff;
      f7_tok_in.side.dyneg = f6_dyneg_ff;
      f7_tok_in.side.am    = f6_am_ff;
      f7_tok_in.side.cm    = f6_cm_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff     <= 1'b0;
         f2_v_ff     <= 1'b0;
         f3_v_ff     <= 1'b0;
         f4_v_ff     <= 1'b0;
         f5_v_ff     <= 1'b0;
         f6_v_ff     <= 1'b0;
         f7_tok_ff.v <= 1'b0;
      end else if (adv) begin
         f1_v_ff <= in_v;
         f2_v_ff <= f1_v_ff;
         f3_v_ff <= f2_v_ff;
         f4_v_ff <= f3_v_ff;
         f5_v_ff <= f4_v_ff;
         f6_v_ff <= f5_v_ff;
         f7_tok_ff <= f7_tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_sx_ff <= f1_sx_in;
         f1_sy_ff <= f1_sy_in;
         f1_ex_ff <= f1_ex_in;
         f1_ey_ff <= f1_ey_in;
         f1_cx_ff <= in_data.center_x;
         f1_cy_ff <= in_data.center_y;
         f1_r_ff  <= in_data.radius;

         f2_dx_ff   <= f2_dx_in;
         f2_dy_ff   <= f2_dy_in;
         f2_p1_ff   <= f2_p1_in;
         f2_p2_ff   <= f2_p2_in;
         f2_r2_ff   <= f2_r2_in;
         f2_minx_ff <= (f1_sx_ff < f1_ex_ff) ? f1_sx_ff : f1_ex_ff;
         f2_maxx_ff <= (f1_sx_ff < f1_ex_ff) ? f1_ex_ff : f1_sx_ff;
         f2_cx_ff   <= f1_cx_ff;
         f2_cy_ff   <= f1_cy_ff;

         f3_det_ff   <= f3_det_in;
         f3_dx2_ff   <= dxsq[65:0];
         f3_dy2_ff   <= dysq[65:0];
         f3_dxm_ff   <= f3_dxm_in;
         f3_dym_ff   <= f3_dym_in;
         f3_dxneg_ff <= f2_dx_ff[DltW-1];
         f3_dyneg_ff <= f2_dy_ff[DltW-1];
         f3_r2_ff    <= f2_r2_ff;
         f3_minx_ff  <= f2_minx_ff;
         f3_maxx_ff  <= f2_maxx_ff;
         f3_cx_ff    <= f2_cx_ff;
         f3_cy_ff    <= f2_cy_ff;

         f4_len2_ff  <= f4_len2_in;
         f4_dmag_ff  <= f4_dmag_in;
         f4_dneg_ff  <= f3_det_ff[65];
         f4_dxm_ff   <= f3_dxm_ff;
         f4_dym_ff   <= f3_dym_ff;
         f4_dxneg_ff <= f3_dxneg_ff;
         f4_dyneg_ff <= f3_dyneg_ff;
         f4_r2_ff    <= f3_r2_ff;
         f4_minx_ff  <= f3_minx_ff;
         f4_maxx_ff  <= f3_maxx_ff;
         f4_cx_ff    <= f3_cx_ff;
         f4_cy_ff    <= f3_cy_ff;

         f5_rll_ff   <= f4_r2_ff[30:0] * f4_len2_ff[33:0];
         f5_rlh_ff   <= f4_r2_ff[30:0] * f4_len2_ff[66:34];
         f5_rhl_ff   <= f4_r2_ff[61:31] * f4_len2_ff[33:0];
         f5_rhh_ff   <= f4_r2_ff[61:31] * f4_len2_ff[66:34];
         f5_dll_ff   <= f4_dmag_ff[31:0] * f4_dmag_ff[31:0];
         f5_dlh_ff   <= f4_dmag_ff[31:0] * f4_dmag_ff[63:32];
         f5_dhh_ff   <= f4_dmag_ff[63:32] * f4_dmag_ff[63:32];
         f5_aml_ff   <= f4_dmag_ff[31:0] * f4_dym_ff;
         f5_amh_ff   <= f4_dmag_ff[63:32] * f4_dym_ff;
         f5_cml_ff   <= f4_dmag_ff[31:0] * f4_dxm_ff;
         f5_cmh_ff   <= f4_dmag_ff[63:32] * f4_dxm_ff;
         // drop zero-length segments and determinants too wide for the formula
         f5_ok_ff    <= (|f4_len2_ff) & ~f4_dmag_ff[64];
         f5_len2_ff  <= f4_len2_ff;
         f5_dneg_ff  <= f4_dneg_ff;
         f5_dxm_ff   <= f4_dxm_ff;
         f5_dym_ff   <= f4_dym_ff;
         f5_dxneg_ff <= f4_dxneg_ff;
         f5_dyneg_ff <= f4_dyneg_ff;
         f5_minx_ff  <= f4_minx_ff;
         f5_maxx_ff  <= f4_maxx_ff;
         f5_cx_ff    <= f4_cx_ff;
         f5_cy_ff    <= f4_cy_ff;

         f6_rl_ff    <= f6_rl_in;
         f6_d2_ff    <= f6_d2_in;
         f6_am_ff    <= f6_am_in;
         f6_cm_ff    <= f6_cm_in;
         f6_ok_ff    <= f5_ok_ff;
         f6_len2_ff  <= f5_len2_ff;
         f6_dneg_ff  <= f5_dneg_ff;
         f6_dxm_ff   <= f5_dxm_ff;
         f6_dym_ff   <= f5_dym_ff;
         f6_dxneg_ff <= f5_dxneg_ff;
         f6_dyneg_ff <= f5_dyneg_ff;
         f6_minx_ff  <= f5_minx_ff;
         f6_maxx_ff  <= f5_maxx_ff;
         f6_cx_ff    <= f5_cx_ff;
         f6_cy_ff    <= f5_cy_ff;
      end
   end

   assign out_tok = f7_tok_ff;

endmodule

// ===== rtl/core/scci_mid.sv =====
// Middle pipeline: square-root result to four signed numerators and divider setup.
// Depends on scci_pkg; sits between the root cells and the divider cells.
module scci_mid import scci_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           adv,
   input  root_token_type in_tok,
   output div_token_type  out_tok
);

   logic               m1_v_ff, m2_v_ff, m3_v_ff, m4_v_ff, m5_v_ff;
   root_side_type      m1_side_ff, m2_side_ff, m3_side_ff;
   logic [64:0]        m1_bh_ff, m1_bl_ff, m1_dh_ff, m1_dl_ff;
   logic [ProdW-1:0]   m2_bm_ff, m2_dm_ff, m2_bm_in, m2_dm_in;
   logic signed [NumW-1:0] a_pos, b_pos, c_pos, d_pos;
   logic signed [NumW-1:0] m3_a_ff, m3_b_ff, m3_c_ff, m3_d_ff;
   logic signed [NumW-1:0] m3_a_in, m3_b_in, m3_c_in;
   logic signed [NumW-1:0] m4_num_ff [Lanes];
   logic signed [NumW-1:0] m4_num_in [Lanes];
   logic signed [NumW-1:0] nneg      [Lanes];
   logic [NumMagW-1:0]     m5_mag_ff [Lanes];
   logic [NumMagW-1:0]     m5_mag_in [Lanes];
   logic [Lanes-1:0]       m5_neg_ff;
   logic                   m4_ok_ff, m5_ok_ff;
   logic signed [CrdW-1:0] m4_minx_ff, m4_maxx_ff, m5_minx_ff, m5_maxx_ff;
   logic signed [31:0]     m4_cx_ff, m4_cy_ff, m5_cx_ff, m5_cy_ff;
   logic [LenW-1:0]        m4_len2_ff, m5_len2_ff;
   div_token_type          m6_tok_ff, m6_tok_in;

   always_comb begin
      m2_bm_in = ProdW'(m1_bl_ff) + (ProdW'(m1_bh_ff) << 32);
      m2_dm_in = ProdW'(m1_dl_ff) + (ProdW'(m1_dh_ff) << 32);

      a_pos = {2'b00, m2_side_ff.am};
      b_pos = {2'b00, m2_bm_ff};
      c_pos = {2'b00, m2_side_ff.cm};
      d_pos = {2'b00, m2_dm_ff};
      m3_a_in = (m2_side_ff.dneg ^ m2_side_ff.dyneg) ? -a_pos : a_pos;
      m3_b_in = (m2_side_ff.dxneg ^ m2_side_ff.dyneg) ? -b_pos : b_pos;
      // c carries the minus sign of -det*dx
      m3_c_in = (m2_side_ff.dneg ^ m2_side_ff.dxneg) ? c_pos : -c_pos;

      m4_num_in[LaneX0] = m3_a_ff + m3_b_ff;
      m4_num_in[LaneX1] = m3_a_ff - m3_b_ff;
      m4_num_in[LaneY0] = m3_c_ff + m3_d_ff;
      m4_num_in[LaneY1] = m3_c_ff - m3_d_ff;

      for (int k = 0; k < Lanes; k++) begin
         nneg[k]      = -m4_num_ff[k];
         m5_mag_in[k] = m4_num_ff[k][NumW-1] ? nneg[k][NumMagW-1:0]
                                             : m4_num_ff[k][NumMagW-1:0];
      end

      m6_tok_in.v         = m5_v_ff;
      m6_tok_in.side.ok   = m5_ok_ff;
      m6_tok_in.side.minx = m5_minx_ff;
      m6_tok_in.side.maxx = m5_maxx_ff;
      m6_tok_in.side.cx   = m5_cx_ff;
      m6_tok_in.side.cy   = m5_cy_ff;
      m6_tok_in.side.len2 = m5_len2_ff;
      m6_tok_in.side.neg  = m5_neg_ff;
      for (int k = 0; k < Lanes; k++) begin
         // quotient of 2^QW or more never lands in the span and saturates y
         m6_tok_in.side.ovf[k] = LenW'(m5_mag_ff[k][NumMagW-1:QW]) >= m5_len2_ff;
         m6_tok_in.lane[k].rem = DivRemW'(m5_mag_ff[k][NumMagW-1:QW]);
         m6_tok_in.lane[k].lo  = m5_mag_ff[k][QW-1:0];
         m6_tok_in.lane[k].q   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff     <= 1'b0;
         m2_v_ff     <= 1'b0;
         m3_v_ff     <= 1'b0;
         m4_v_ff     <= 1'b0;
         m5_v_ff     <= 1'b0;
         m6_tok_ff.v <= 1'b0;
      end else if (adv) begin
         m1_v_ff   <= in_tok.v;
         m2_v_ff   <= m1_v_ff;
         m3_v_ff   <= m2_v_ff;
         m4_v_ff   <= m3_v_ff;
         m5_v_ff   <= m4_v_ff;
         m6_tok_ff <= m6_tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_side_ff <= in_tok.side;
         m1_bh_ff   <= in_tok.side.dxm * in_tok.root[63:32];
         m1_bl_ff   <= in_tok.side.dxm * in_tok.root[31:0];
         m1_dh_ff   <= in_tok.side.dym * in_tok.root[63:32];
         m1_dl_ff   <= in_tok.side.dym * in_tok.root[31:0];

         m2_side_ff <= m1_side_ff;
         m2_bm_ff   <= m2_bm_in;
         m2_dm_ff   <= m2_dm_in;

         m3_side_ff <= m2_side_ff;
         m3_a_ff    <= m3_a_in;
         m3_b_ff    <= m3_b_in;
         m3_c_ff    <= m3_c_in;
         m3_d_ff    <= d_pos;

         m4_num_ff  <= m4_num_in;
         m4_ok_ff   <= m3_side_ff.ok;
         m4_minx_ff <= m3_side_ff.minx;
         m4_maxx_ff <= m3_side_ff.maxx;
         m4_cx_ff   <= m3_side_ff.cx;
         m4_cy_ff   <= m3_side_ff.cy;
         m4_len2_ff <= m3_side_ff.len2;

         m5_mag_ff  <= m5_mag_in;
         for (int k = 0; k < Lanes; k++) begin
            m5_neg_ff[k] <= m4_num_ff[k][NumW-1];
         end
         m5_ok_ff   <= m4_ok_ff;
         m5_minx_ff <= m4_minx_ff;
         m5_maxx_ff <= m4_maxx_ff;
         m5_cx_ff   <= m4_cx_ff;
         m5_cy_ff   <= m4_cy_ff;
         m5_len2_ff <= m4_len2_ff;
      end
   end

   assign out_tok = m6_tok_ff;

endmodule

// ===== rtl/core/segment_circle_intersection_core.sv =====
// Segment/circle intersection core: top level with root and divider cell chains.
// Depends on scci_pkg, scci_front, scci_root_cell, scci_mid and scci_div_cell.
//
// Takes one segment/circle pair per cycle unless req_stall is high, and returns one
// or two points, or one empty transaction (found low) when the segment misses the
// circle or has zero length; last marks the final result of each pair. Between an
// accepted request and its first result lie 7 front stages, 64 square-root cells
// (one root bit each), 6 numerator stages, 40 divider cells (one quotient bit
// each, four lanes), 2 output stages and the result register. The chain takes a
// pair every cycle; a pair with two points holds the result port for both of its
// transactions, so the sustained rate is one pair per cycle when each pair yields
// at most one transaction and the result side does not stall. The whole chain holds
// while its last stage is full and cannot hand over to the result register.
module segment_circle_intersection_core import scci_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic           adv;
   root_token_type root_tok [RootW+1];
   div_token_type  div_tok  [QW+1];

   scci_front u_front (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_v    (req_valid),
      .in_data (req_data),
      .out_tok (root_tok[0])
   );

   for (genvar i = 0; i < RootW; i++) begin : g_root
      scci_root_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .up_tok (root_tok[i]),
         .dn_tok (root_tok[i+1])
      );
   end

   scci_mid u_mid (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_tok  (root_tok[RootW]),
      .out_tok (div_tok[0])
   );

   for (genvar i = 0; i < QW; i++) begin : g_div
      scci_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .up_tok (div_tok[i]),
         .dn_tok (div_tok[i+1])
      );
   end

   div_token_type dq;
   assign dq = div_tok[QW];

   // output stage 1: signed quotients and span test
   logic                   p1_v_ff;
   logic signed [QW:0]     sq [Lanes];
   logic signed [QW:0]     p1_x0_ff, p1_y0_ff, p1_x1_ff, p1_y1_ff;
   logic                   p1_k0_ff, p1_k1_ff, p1_k0_in, p1_k1_in;
   logic                   p1_ovy0_ff, p1_ovy1_ff, p1_ny0_ff, p1_ny1_ff;
   logic signed [31:0]     p1_cx_ff, p1_cy_ff;

   // output stage 2: shifted back, saturated and compacted
   logic                   p2_v_ff;
   logic [1:0]             p2_cnt_ff;
   logic signed [31:0]     p2_x0_ff, p2_y0_ff, p2_x1_ff, p2_y1_ff;
   logic signed [41:0]     sum_x0, sum_y0, sum_x1, sum_y1;
   logic signed [31:0]     fx0, fy0, fx1, fy1;

   // result register
   logic                   em_v_ff, em_idx_ff;
   logic [1:0]             em_cnt_ff;
   logic signed [31:0]     em_x0_ff, em_y0_ff, em_x1_ff, em_y1_ff;
   logic                   em_last, take;

   always_comb begin
      for (int k = 0; k < Lanes; k++) begin
         sq[k] = dq.side.neg[k] ? -$signed({1'b0, dq.lane[k].q})
                                : $signed({1'b0, dq.lane[k].q});
      end
      p1_k0_in = dq.side.ok & ~dq.side.ovf[LaneX0]
               & (sq[LaneX0] >= dq.side.minx) & (sq[LaneX0] <= dq.side.maxx);
      p1_k1_in = dq.side.ok & ~dq.side.ovf[LaneX1]
               & (sq[LaneX1] >= dq.side.minx) & (sq[LaneX1] <= dq.side.maxx);

      sum_x0 = 42'(p1_x0_ff) + 42'(p1_cx_ff);
      sum_x1 = 42'(p1_x1_ff) + 42'(p1_cx_ff);
      sum_y0 = 42'(p1_y0_ff) + 42'(p1_cy_ff);
      sum_y1 = 42'(p1_y1_ff) + 42'(p1_cy_ff);
      fx0 = sat32(sum_x0);
      fx1 = sat32(sum_x1);
      // an overflowed y quotient saturates toward its sign
      fy0 = p1_ovy0_ff ? (p1_ny0_ff ? 32'sh80000000 : 32'sh7fffffff) : sat32(sum_y0);
      fy1 = p1_ovy1_ff ? (p1_ny1_ff ? 32'sh80000000 : 32'sh7fffffff) : sat32(sum_y1);

      em_last = (em_cnt_ff != 2'd2) | em_idx_ff;
      take    = ~em_v_ff | (~rsp_stall & em_last);
      adv     = ~p2_v_ff | take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff   <= 1'b0;
         p2_v_ff   <= 1'b0;
         em_v_ff   <= 1'b0;
         em_idx_ff <= 1'b0;
      end else begin
         if (adv) begin
            p1_v_ff <= dq.v;
            p2_v_ff <= p1_v_ff;
         end
         if (take) begin
            em_v_ff   <= p2_v_ff;
            em_idx_ff <= 1'b0;
         end else if (!rsp_stall) begin
            // first of two points went out: advance to the second
            em_idx_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_x0_ff   <= sq[LaneX0];
         p1_y0_ff   <= sq[LaneY0];
         p1_x1_ff   <= sq[LaneX1];
         p1_y1_ff   <= sq[LaneY1];
         p1_k0_ff   <= p1_k0_in;
         p1_k1_ff   <= p1_k1_in;
         p1_ovy0_ff <= dq.side.ovf[LaneY0];
         p1_ovy1_ff <= dq.side.ovf[LaneY1];
         p1_ny0_ff  <= dq.side.neg[LaneY0];
         p1_ny1_ff  <= dq.side.neg[LaneY1];
         p1_cx_ff   <= dq.side.cx;
         p1_cy_ff   <= dq.side.cy;

         p2_cnt_ff <= {1'b0, p1_k0_ff} + {1'b0, p1_k1_ff};
         p2_x0_ff  <= p1_k0_ff ? fx0 : (p1_k1_ff ? fx1 : '0);
         p2_y0_ff  <= p1_k0_ff ? fy0 : (p1_k1_ff ? fy1 : '0);
         p2_x1_ff  <= fx1;
         p2_y1_ff  <= fy1;
      end
      if (take) begin
         em_cnt_ff <= p2_cnt_ff;
         em_x0_ff  <= p2_x0_ff;
         em_y0_ff  <= p2_y0_ff;
         em_x1_ff  <= p2_x1_ff;
         em_y1_ff  <= p2_y1_ff;
      end
   end

   assign req_stall        = ~adv;
   assign rsp_valid        = em_v_ff;
   assign rsp_data.point_x = em_idx_ff ? em_x1_ff : em_x0_ff;
   assign rsp_data.point_y = em_idx_ff ? em_y1_ff : em_y0_ff;
   assign rsp_data.found   = em_cnt_ff != 2'd0;
   assign rsp_data.last    = em_last;

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.last)
      else $error("empty result not marked last");

   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request side held with no pending result");

   a_second_point_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=> rsp_valid && rsp_data.found)
      else $error("second point missing after first");

endmodule
